@@ design/pmtup_pkg.sv @@
// ----------------------------------------------------------------------------
// Path MTU prober package
// Shared types, codes and constants of the path MTU probe controller.
// ----------------------------------------------------------------------------
package pmtup_pkg;

  // Width of every size in the prober state; covers the full MTU range.
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned PROBE_W     = 15;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned RETRY_W     = 4;
  localparam int unsigned CHECK_W     = 3;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // Defaults of the top-level parameters.
  localparam int unsigned PMTU_CAP_DEF    = 16384;
  localparam int unsigned RETRY_LIMIT_DEF = 10;
  localparam int unsigned CHECK_LIMIT_DEF = 5;

  // Fixed protocol sizes and steps.
  localparam logic [SIZE_W-1:0]  GROW_STEP     = 16'd50;
  localparam logic [SIZE_W-1:0]  BASE_V6       = 16'd1280;
  localparam logic [SIZE_W-1:0]  BASE_V4       = 16'd1200;
  localparam logic [SIZE_W-1:0]  MIN_V6        = 16'd1280;
  localparam logic [SIZE_W-1:0]  MIN_V4        = 16'd68;
  localparam logic [SIZE_W-1:0]  CEIL_UNKNOWN  = 16'd1500;
  localparam logic [RETRY_W-1:0] RETRY_SAT     = 4'd15;
  localparam logic [CHECK_W-1:0] CHECK_SAT     = 3'd7;

  // Prober phases.
  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_DISABLED = 3'd1,
    PH_BASE     = 3'd2,
    PH_SEARCH   = 3'd3,
    PH_ERROR    = 3'd4,
    PH_DONE     = 3'd5
  } phase_e;

  // Event codes carried by a request.
  typedef enum logic [FUNC_W-1:0] {
    FN_START      = 3'd0,
    FN_ACK        = 3'd1,
    FN_TOO_BIG    = 3'd2,
    FN_PROBE_TMO  = 3'd3,
    FN_VALID_TMO  = 3'd4,
    FN_REMOTE_MTU = 3'd5
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IPV4_MODE    = 1'd0,
    REG_LOCAL_IF_MTU = 1'd1
  } cfg_reg_e;

  // Input request.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [15:0]       reported_mtu;
    logic [15:0]       remote_mtu;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic               send_now;
    logic [PROBE_W-1:0] probe_bytes;
    logic               probe_flag;
    logic [SEQ_W-1:0]   probe_seq;
    logic               arm_probe_timer;
    logic               cancel_probe_timer;
    logic               arm_validation_timer;
    logic [2:0]         fsm_code;
    logic [PROBE_W-1:0] confirmed_mtu;
  } out_item_t;

  // Prober state.
  typedef struct packed {
    phase_e             phase;
    logic [SIZE_W-1:0]  trial_size;
    logic [SIZE_W-1:0]  good_size;
    logic [SIZE_W-1:0]  ceiling;
    logic [SEQ_W-1:0]   seq_counter;
    logic [SIZE_W-1:0]  report_limit;
    logic [RETRY_W-1:0] retry_count;
    logic [CHECK_W-1:0] check_count;
    logic [SIZE_W-1:0]  peer_mtu;
  } state_t;

endpackage

@@ design/pmtup_step.sv @@
// ----------------------------------------------------------------------------
// Path MTU prober step logic
// Computes the next prober state and the result item for one event.
// ----------------------------------------------------------------------------
module pmtup_step import pmtup_pkg::*; #(
  parameter int unsigned PMTU_CAP    = PMTU_CAP_DEF,
  parameter int unsigned RETRY_LIMIT = RETRY_LIMIT_DEF,
  parameter int unsigned CHECK_LIMIT = CHECK_LIMIT_DEF
) (
  input  state_t            state_i,
  input  logic              ipv4_mode_i,
  input  logic [SIZE_W-1:0] local_if_mtu_i,
  input  in_item_t          item_i,
  output state_t            state_o,
  output out_item_t         rsp_o
);

  localparam logic [SIZE_W-1:0]  CapSize    = SIZE_W'(PMTU_CAP);
  localparam logic [RETRY_W-1:0] RetryLimit = RETRY_W'(RETRY_LIMIT);
  localparam logic [CHECK_W-1:0] CheckLimit = CHECK_W'(CHECK_LIMIT);

  // Grow the trial size by one step, clipped at the ceiling.
  function automatic state_t grow_trial(state_t s);
    logic [SIZE_W:0] sum;
    sum = {1'b0, s.trial_size} + {1'b0, GROW_STEP};
    if (sum > {1'b0, s.ceiling}) begin
      s.trial_size = s.ceiling;
    end else begin
      s.trial_size = sum[SIZE_W-1:0];
    end
    return s;
  endfunction

  // Ceiling from the known interface MTUs, capped.
  function automatic state_t refresh_ceiling(state_t s, logic [SIZE_W-1:0] lmtu);
    logic [SIZE_W-1:0] m;
    m = lmtu;
    if (m == '0) begin
      m = s.peer_mtu;
    end else if (s.peer_mtu != '0 && s.peer_mtu < m) begin
      m = s.peer_mtu;
    end
    if (m == '0) begin
      s.ceiling = CEIL_UNKNOWN;
    end else if (m > CapSize) begin
      s.ceiling = CapSize;
    end else begin
      s.ceiling = m;
    end
    return s;
  endfunction

  function automatic state_t enter_base(state_t s, logic v4);
    s.phase       = PH_BASE;
    s.trial_size  = v4 ? BASE_V4 : BASE_V6;
    s.retry_count = '0;
    s.peer_mtu    = '0;
    return s;
  endfunction

  function automatic state_t enter_error(state_t s, logic v4);
    s.phase       = PH_ERROR;
    s.trial_size  = v4 ? MIN_V4 : MIN_V6;
    s.retry_count = '0;
    s.peer_mtu    = '0;
    return s;
  endfunction

  function automatic state_t enter_done(state_t s);
    s.phase        = PH_DONE;
    s.trial_size   = s.good_size;
    s.report_limit = s.good_size;
    s.check_count  = '0;
    return s;
  endfunction

  function automatic state_t enter_search(state_t s, logic [SIZE_W-1:0] lmtu);
    s.phase        = PH_SEARCH;
    s              = refresh_ceiling(s, lmtu);
    s.good_size    = s.trial_size;
    s              = grow_trial(s);
    s.report_limit = s.trial_size;
    s.retry_count  = '0;
    return s;
  endfunction

  state_t            ns;
  logic              send;
  logic              flag;
  logic              cancel;
  logic              varm;
  logic [SIZE_W-1:0] base_sz;
  logic [SIZE_W-1:0] rep_mtu;

  assign base_sz = ipv4_mode_i ? BASE_V4 : BASE_V6;
  assign rep_mtu = SIZE_W'(item_i.reported_mtu);

  // Event decode and state transitions. A probe send is always the last action of
  // a path, so the sequence and retry updates are applied once at the end.
  always_comb begin
    ns     = state_i;
    send   = 1'b0;
    flag   = 1'b0;
    cancel = 1'b0;
    varm   = 1'b0;

    case (item_i.func)
      FN_START: begin
        ns.report_limit = '0;
        ns.seq_counter  = '0;
        ns.peer_mtu     = '0;
        ns.phase        = PH_START;
        ns.trial_size   = '0;
        ns.retry_count  = '0;
        send            = 1'b1;
      end

      FN_ACK: begin
        cancel = 1'b1;
        case (state_i.phase)
          PH_START: begin
            ns   = enter_base(ns, ipv4_mode_i);
            send = 1'b1;
            flag = 1'b1;
          end
          PH_BASE, PH_ERROR: begin
            ns   = enter_search(ns, local_if_mtu_i);
            send = 1'b1;
          end
          PH_SEARCH: begin
            ns.good_size = ns.trial_size;
            if (ns.good_size == ns.ceiling) begin
              ns   = enter_done(ns);
              varm = 1'b1;
            end else begin
              ns              = grow_trial(ns);
              ns.report_limit = ns.trial_size;
              ns.retry_count  = '0;
              send            = 1'b1;
            end
          end
          PH_DONE: begin
            if (state_i.check_count < CheckLimit) begin
              varm = 1'b1;
            end else begin
              ns   = enter_search(ns, local_if_mtu_i);
              send = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      FN_TOO_BIG: begin
        if (state_i.phase inside {PH_BASE, PH_SEARCH, PH_DONE}) begin
          if (state_i.report_limit == '0 || rep_mtu < state_i.report_limit) begin
            cancel = 1'b1;
          end
          case (state_i.phase)
            PH_BASE: begin
              if (rep_mtu < base_sz) begin
                ns   = enter_error(ns, ipv4_mode_i);
                send = 1'b1;
                flag = 1'b1;
              end else begin
                ns   = enter_done(ns);
                varm = 1'b1;
              end
            end
            PH_SEARCH: begin
              if (rep_mtu < state_i.good_size) begin
                ns   = enter_base(ns, ipv4_mode_i);
                send = 1'b1;
                flag = 1'b1;
              end else if (rep_mtu < state_i.trial_size) begin
                ns.trial_size = rep_mtu;
                ns.ceiling    = rep_mtu;
                if (state_i.good_size == rep_mtu) begin
                  ns   = enter_done(ns);
                  varm = 1'b1;
                end else begin
                  ns.retry_count = '0;
                  send           = 1'b1;
                end
              end
            end
            default: begin
              if (rep_mtu < state_i.good_size) begin
                ns   = enter_base(ns, ipv4_mode_i);
                send = 1'b1;
                flag = 1'b1;
              end
            end
          endcase
        end
      end

      FN_PROBE_TMO: begin
        if (state_i.retry_count == RetryLimit) begin
          // Retries used up: the probe is taken as failed.
          case (state_i.phase)
            PH_START: begin
              ns.phase = PH_DISABLED;
            end
            PH_BASE: begin
              ns   = enter_error(ns, ipv4_mode_i);
              send = 1'b1;
              flag = 1'b1;
            end
            PH_SEARCH: begin
              ns   = enter_done(ns);
              varm = 1'b1;
            end
            PH_ERROR: begin
              ns.retry_count = '0;
              send           = 1'b1;
            end
            PH_DONE: begin
              ns   = enter_base(ns, ipv4_mode_i);
              send = 1'b1;
              flag = 1'b1;
            end
            default: begin
            end
          endcase
        end else begin
          send = 1'b1;
        end
      end

      FN_VALID_TMO: begin
        if (state_i.check_count < CHECK_SAT) begin
          ns.check_count = state_i.check_count + 1'b1;
        end
        ns.retry_count = '0;
        send           = 1'b1;
        if (ns.check_count >= CheckLimit) begin
          ns.peer_mtu = '0;
          flag        = 1'b1;
        end
      end

      FN_REMOTE_MTU: begin
        ns.peer_mtu = SIZE_W'(item_i.remote_mtu);
      end

      default: begin
      end
    endcase

    // Probe send bookkeeping.
    if (send) begin
      ns.seq_counter = ns.seq_counter + 1'b1;
      if (ns.retry_count < RETRY_SAT) begin
        ns.retry_count = ns.retry_count + 1'b1;
      end
    end
  end

  // Result item.
  always_comb begin
    rsp_o                      = '0;
    rsp_o.send_now             = send;
    rsp_o.arm_probe_timer      = send;
    rsp_o.cancel_probe_timer   = cancel;
    rsp_o.arm_validation_timer = varm;
    rsp_o.fsm_code             = ns.phase;
    rsp_o.confirmed_mtu        = PROBE_W'(ns.good_size);
    if (send) begin
      rsp_o.probe_bytes = PROBE_W'(ns.trial_size);
      rsp_o.probe_flag  = flag;
      rsp_o.probe_seq   = ns.seq_counter;
    end
  end

  assign state_o = ns;

endmodule

@@ design/path_mtu_probe_controller_top.sv @@
// ----------------------------------------------------------------------------
// Path MTU probe controller
// Packetization-layer path MTU prober with one event in and one result out.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel carries one event: start, probe ack,
// packet-too-big report, probe timer expiry, validation timer expiry or remote
// interface MTU. Every request yields exactly one result on the output channel,
// telling whether to send a probe (size, flag, sequence), which timer commands
// to issue, the phase after the event and the confirmed size.
// A request sits in the input register after the edge that accepts it; the
// step logic then writes the prober state and the result register once the
// result register is free. One request is taken every cycle while the
// receiver does not stall; the step logic is combinational.
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; the input channel then stops accepting.
// The configuration channel is always ready and writes the IPv4 mode and
// the local interface MTU; write it only while no request is in flight.
// Reset puts the prober in the start phase with all sizes and counts at zero,
// clears both configuration registers and empties both pipeline registers.
// ----------------------------------------------------------------------------
module path_mtu_probe_controller_top import pmtup_pkg::*; #(
  parameter int unsigned PMTU_CAP    = PMTU_CAP_DEF,
  parameter int unsigned RETRY_LIMIT = RETRY_LIMIT_DEF,
  parameter int unsigned CHECK_LIMIT = CHECK_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_rsp_o
);

  logic              ipv4_mode_q;
  logic [SIZE_W-1:0] local_if_mtu_q;
  logic              in_valid_q;
  in_item_t          in_item_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  state_t            state_q;
  state_t            state_d;
  out_item_t         rsp_d;
  logic              advance;
  logic              step_en;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_mode_q    <= 1'b0;
      local_if_mtu_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IPV4_MODE:    ipv4_mode_q    <= cfg_wdata_i[0];
        REG_LOCAL_IF_MTU: local_if_mtu_q <= SIZE_W'(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: the result register frees up when empty or when taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign step_en    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_req_i;
    end
  end

  // Step logic.
  pmtup_step #(
    .PMTU_CAP    (PMTU_CAP),
    .RETRY_LIMIT (RETRY_LIMIT),
    .CHECK_LIMIT (CHECK_LIMIT)
  ) u_step (
    .state_i        (state_q),
    .ipv4_mode_i    (ipv4_mode_q),
    .local_if_mtu_i (local_if_mtu_q),
    .item_i         (in_item_q),
    .state_o        (state_d),
    .rsp_o          (rsp_d)
  );

  // Prober state register. The all-zero state is the start phase with every
  // size and count cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_item_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_item_q;

endmodule
